[sv/se2pc_pkg.sv]
// Shared types and constants for the SE(2) pose composition pipeline.
// Used by every module of the block; depends on nothing else.
package se2pc_pkg;

  // Width of the guarded CORDIC vector: Q.24 positions plus gain growth.
  localparam int XW = 42;
  // Width of the residual angle inside the rotator, Q3.29 plus a sign margin.
  localparam int ZW = 33;
  // Width used for the final sum and the saturation compare.
  localparam int SUMW = 50;
  localparam int GUARD_BITS = 8;

  localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

  localparam logic signed [33:0] ANG_PI = 34'sd1686629713;
  localparam logic signed [33:0] ANG_TWO_PI = 34'sd3373259426;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 33'sd843314857;

  // atan(2^-i) in Q3.29, rounded to nearest.
  localparam logic [ZW-3:0] ATAN_Q29 [32] = '{
    31'd421657428, 31'd248918915, 31'd131521918, 31'd66762579,
    31'd33510843, 31'd16771758, 31'd8387925, 31'd4194219,
    31'd2097141, 31'd1048575, 31'd524288, 31'd262144,
    31'd131072, 31'd65536, 31'd32768, 31'd16384,
    31'd8192, 31'd4096, 31'd2048, 31'd1024,
    31'd512, 31'd256, 31'd128, 31'd64,
    31'd32, 31'd16, 31'd8, 31'd4,
    31'd2, 31'd1, 31'd0, 31'd0
  };

  // Input pose pair; the first member declared sits in the highest bits.
  typedef struct packed {
    logic signed [31:0] rhs_theta;
    logic signed [31:0] rhs_y;
    logic signed [31:0] rhs_x;
    logic signed [31:0] lhs_theta;
    logic signed [31:0] lhs_y;
    logic signed [31:0] lhs_x;
  } pair_t;

  // Composed pose, out_x in the lowest bits.
  typedef struct packed {
    logic signed [31:0] out_theta;
    logic signed [31:0] out_y;
    logic signed [31:0] out_x;
  } res_t;

  // Payload that travels through the rotator stages.
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [31:0]   lx;
    logic signed [31:0]   ly;
    logic signed [31:0]   heading;
  } rot_t;

endpackage

[sv/se2_pose_compose_top.sv]
// SE(2) pose composition: p1 + R(theta1) * p2, heading wrapped into (-pi, pi].
// Stages: two front stages (gain multiply, then quarter-turn), one stage per
// CORDIC micro-rotation, then rounding and the saturating add into the output
// register. One pose pair per cycle is taken; the whole pipeline advances
// together and holds while a result is not taken.
// Synchronous reset empties the pipeline; payload registers are not cleared.
module se2_pose_compose_top
  import se2pc_pkg::*;
#(
  parameter int CORDIC_STAGES = 24,
  parameter int POSITION_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // lhs_x, lhs_y, lhs_theta, rhs_x, rhs_y, rhs_theta, 32 bits each
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_x, out_y, out_theta, 32 bits each
  output logic [95:0]  m_tdata,
  // saturated
  output logic [0:0]   m_tuser
);

  logic en;
  logic pipe_valid [CORDIC_STAGES+1];
  rot_t pipe_data  [CORDIC_STAGES+1];
  res_t res;
  logic sat;

  // Every stage moves on a transfer or whenever the output register is free.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  se2pc_prescale u_prescale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_data   (pair_t'(s_tdata)),
    .out_valid (pipe_valid[0]),
    .out_data  (pipe_data[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    se2pc_cordic_stage #(
      .IDX (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (pipe_valid[i]),
      .in_data   (pipe_data[i]),
      .out_valid (pipe_valid[i+1]),
      .out_data  (pipe_data[i+1])
    );
  end

  se2pc_post #(
    .POSITION_BITS (POSITION_BITS)
  ) u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pipe_valid[CORDIC_STAGES]),
    .in_data   (pipe_data[CORDIC_STAGES]),
    .out_valid (m_tvalid),
    .out_data  (res),
    .out_sat   (sat)
  );

  assign m_tdata = res;
  assign m_tuser = sat;

endmodule

[sv/se2pc_prescale.sv]
// Front of the pipeline: gain pre-scale, heading wrap and sum, quarter-turn
// pre-rotation. Two register stages. Depends on se2pc_pkg.
module se2pc_prescale
  import se2pc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  pair_t in_data,
  output logic  out_valid,
  output rot_t  out_data
);

  logic signed [64:0] prod_x;
  logic signed [64:0] prod_y;
  logic signed [33:0] lt_ext;
  logic signed [33:0] lt_wrap;
  logic signed [33:0] hsum;
  logic signed [33:0] hsum_wrap;

  logic  mid_valid;
  rot_t  mid;
  rot_t  rot_next;

  assign prod_x = $signed(in_data.rhs_x) * $signed({1'b0, GAIN_Q32});
  assign prod_y = $signed(in_data.rhs_y) * $signed({1'b0, GAIN_Q32});

  always_comb begin
    lt_ext = 34'(in_data.lhs_theta);
    if (lt_ext > ANG_PI) begin
      lt_wrap = lt_ext - ANG_TWO_PI;
    end else if (lt_ext <= -ANG_PI) begin
      lt_wrap = lt_ext + ANG_TWO_PI;
    end else begin
      lt_wrap = lt_ext;
    end
    hsum = 34'(in_data.lhs_theta) + 34'(in_data.rhs_theta);
    if (hsum > ANG_PI) begin
      hsum_wrap = hsum - ANG_TWO_PI;
    end else if (hsum <= -ANG_PI) begin
      hsum_wrap = hsum + ANG_TWO_PI;
    end else begin
      hsum_wrap = hsum;
    end
  end

  // The rotator converges only within a quarter turn, so larger headings are
  // first turned by a right angle exactly.
  always_comb begin
    rot_next = mid;
    if (mid.z > ANG_HALF_PI) begin
      rot_next.x = -mid.y;
      rot_next.y = mid.x;
      rot_next.z = mid.z - ANG_HALF_PI;
    end else if (mid.z < -ANG_HALF_PI) begin
      rot_next.x = mid.y;
      rot_next.y = -mid.x;
      rot_next.z = mid.z + ANG_HALF_PI;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
    if (en) begin
      mid.x       <= XW'(prod_x >>> (32 - GUARD_BITS));
      mid.y       <= XW'(prod_y >>> (32 - GUARD_BITS));
      mid.z       <= ZW'(lt_wrap);
      mid.lx      <= in_data.lhs_x;
      mid.ly      <= in_data.lhs_y;
      mid.heading <= hsum_wrap[31:0];
      out_data    <= rot_next;
    end
  end

endmodule

[sv/se2pc_cordic_stage.sv]
// One micro-rotation of the CORDIC rotator, registered.
// Depends on se2pc_pkg for the payload type and the arctangent table.
module se2pc_cordic_stage
  import se2pc_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  rot_t in_data,
  output logic out_valid,
  output rot_t out_data
);

  localparam logic signed [ZW-1:0] ATAN_STEP = $signed({2'b00, ATAN_Q29[IDX]});

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  rot_t                 stage_next;

  assign xs = in_data.x >>> IDX;
  assign ys = in_data.y >>> IDX;

  always_comb begin
    stage_next = in_data;
    if (!in_data.z[ZW-1]) begin
      stage_next.x = in_data.x - ys;
      stage_next.y = in_data.y + xs;
      stage_next.z = in_data.z - ATAN_STEP;
    end else begin
      stage_next.x = in_data.x + ys;
      stage_next.y = in_data.y - xs;
      stage_next.z = in_data.z + ATAN_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_data <= stage_next;
    end
  end

endmodule

[sv/se2pc_post.sv]
// Back of the pipeline: rounds the rotated vector to Q16.16, adds the first
// position, saturates and holds the output register. Depends on se2pc_pkg.
module se2pc_post
  import se2pc_pkg::*;
#(
  parameter int POSITION_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  rot_t in_data,
  output logic out_valid,
  output res_t out_data,
  output logic out_sat
);

  localparam logic signed [SUMW-1:0] POS_HI =
    SUMW'((64'sd1 <<< (POSITION_BITS - 1)) - 64'sd1);
  localparam logic signed [SUMW-1:0] POS_LO = -POS_HI - SUMW'(1);
  localparam logic signed [XW-1:0] ROUND_HALF = XW'(1) <<< (GUARD_BITS - 1);

  typedef struct packed {
    logic signed [XW-GUARD_BITS-1:0] px;
    logic signed [XW-GUARD_BITS-1:0] py;
    logic signed [31:0]              lx;
    logic signed [31:0]              ly;
    logic signed [31:0]              heading;
  } rnd_t;

  logic signed [XW-1:0] xr_full;
  logic signed [XW-1:0] yr_full;
  logic                 rnd_valid;
  rnd_t                 rnd;
  logic signed [SUMW-1:0] sum_x;
  logic signed [SUMW-1:0] sum_y;
  logic signed [SUMW-1:0] sat_x;
  logic signed [SUMW-1:0] sat_y;
  logic                 clip_x;
  logic                 clip_y;

  assign xr_full = (in_data.x + ROUND_HALF) >>> GUARD_BITS;
  assign yr_full = (in_data.y + ROUND_HALF) >>> GUARD_BITS;

  assign sum_x = SUMW'(rnd.px) + SUMW'(rnd.lx);
  assign sum_y = SUMW'(rnd.py) + SUMW'(rnd.ly);

  always_comb begin
    clip_x = 1'b1;
    if (sum_x > POS_HI) begin
      sat_x = POS_HI;
    end else if (sum_x < POS_LO) begin
      sat_x = POS_LO;
    end else begin
      sat_x  = sum_x;
      clip_x = 1'b0;
    end
    clip_y = 1'b1;
    if (sum_y > POS_HI) begin
      sat_y = POS_HI;
    end else if (sum_y < POS_LO) begin
      sat_y = POS_LO;
    end else begin
      sat_y  = sum_y;
      clip_y = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      rnd_valid <= in_valid;
      out_valid <= rnd_valid;
    end
    if (en) begin
      rnd.px             <= xr_full[XW-GUARD_BITS-1:0];
      rnd.py             <= yr_full[XW-GUARD_BITS-1:0];
      rnd.lx             <= in_data.lx;
      rnd.ly             <= in_data.ly;
      rnd.heading        <= in_data.heading;
      out_data.out_x     <= sat_x[31:0];
      out_data.out_y     <= sat_y[31:0];
      out_data.out_theta <= rnd.heading;
      out_sat            <= clip_x | clip_y;
    end
  end

endmodule
